/* rtl/tick_process_scheduler_macros.svh */
// Assertion macros for the tick process scheduler checker.
// Used by tps_checker; no other dependencies.
`ifndef TICK_PROCESS_SCHEDULER_MACROS_SVH
`define TICK_PROCESS_SCHEDULER_MACROS_SVH

// Assert that a condition implies a consequence in the same cycle.
`define TPS_ASSERT_IMPL(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("tps check failed");

// Assert that a condition implies a consequence in the following cycle.
`define TPS_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("tps check failed");

`endif

/* rtl/tps_pkg.sv */
// Shared types and constants for the tick process scheduler.
// No dependencies.
package tps_pkg;

  localparam logic [2:0] POL_FCFS = 3'd0;
  localparam logic [2:0] POL_SJF  = 3'd1;
  localparam logic [2:0] POL_PRIO = 3'd2;
  localparam logic [2:0] POL_SRT  = 3'd3;
  localparam logic [2:0] POL_RR   = 3'd4;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // write the input slot
    logic scan_start; // clear scan state, latch policy
    logic scan_step;  // examine one slot
    logic commit;     // apply decision, build result
  } tps_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;  // the slot being examined is the last
  } tps_sts_t;

endpackage

/* rtl/tick_process_scheduler.sv */
// Top level of the tick process scheduler: controller, datapath, output register.
// Depends on tps_pkg, tps_ctrl and tps_datapath.
//
// Channel | Direction | Payload
// in_     | slave     | tdata {arrival_tick,burst_time,proc_priority,slot_index}, tuser operation
// out_    | master    | tdata {remaining_after,running_slot,run_status,current_tick}
// cfg_    | write     | policy_mode
//
// A load transaction writes its slot when accepted. A tick has a start step, a
// sequential min scan that examines one slot per cycle, and a commit.
// Reset clears remaining times, time, current slot and quantum count.
// A stalled output holds the commit; no new transaction is taken meanwhile.
module tick_process_scheduler
  import tps_pkg::*;
#(
  parameter int NUM_SLOTS = 8,
  parameter int RR_QUANTUM = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // slot_index[2:0], proc_priority, burst_time, arrival_tick, 5 pad
  input  logic        in_tuser,  // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // current_tick, run_status, running_slot, remaining_after, 3 pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata
);

  logic [2:0] policy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) policy_r <= POL_FCFS;
    else if (cfg_we) policy_r <= cfg_wdata;
  end

  tps_cmd_t cmd;
  tps_sts_t sts;
  logic in_fire, res_valid, hold_r;
  logic [15:0] res_tick;
  logic [1:0] res_status;
  logic [2:0] res_slot;
  logic [7:0] res_rem;

  assign in_fire = in_tvalid && in_tready;

  tps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_op(in_tuser),
    .out_busy(out_tvalid && !out_tready), .sts(sts), .in_ready(in_tready), .cmd(cmd)
  );

  tps_datapath #(.NUM_SLOTS(NUM_SLOTS), .RR_QUANTUM(RR_QUANTUM)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .policy(policy_r),
    .in_slot(in_tdata[2:0]), .in_prio(in_tdata[10:3]), .in_burst(in_tdata[18:11]),
    .in_arr(in_tdata[34:19]), .res_valid(res_valid), .res_tick(res_tick),
    .res_status(res_status), .res_slot(res_slot), .res_rem(res_rem)
  );

  // Output valid: set on commit, cleared when taken
  always_ff @(posedge clk) begin
    if (!rst_n) hold_r <= 1'b0;
    else if (cmd.commit) hold_r <= 1'b1;
    else if (out_tready) hold_r <= 1'b0;
  end

  assign out_tvalid = hold_r && res_valid;
  assign out_tdata = {3'd0, res_rem, res_slot, res_status, res_tick};

endmodule

/* rtl/tps_ctrl.sv */
// Controller state machine for the tick process scheduler.
// Depends on tps_pkg.
module tps_ctrl
  import tps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     in_op,
  input  logic     out_busy,
  input  tps_sts_t sts,
  output logic     in_ready,
  output tps_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_op == OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        // wait for a free output register
        if (!out_busy) begin
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

/* rtl/tps_datapath.sv */
// Slot table, sequential min scan and result register of the scheduler.
// Depends on tps_pkg.
module tps_datapath
  import tps_pkg::*;
#(
  parameter int NUM_SLOTS = 8,
  parameter int RR_QUANTUM = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tps_cmd_t    cmd,
  output tps_sts_t    sts,
  input  logic [2:0]  policy,
  input  logic [2:0]  in_slot,
  input  logic [7:0]  in_prio,
  input  logic [7:0]  in_burst,
  input  logic [15:0] in_arr,
  output logic        res_valid,
  output logic [15:0] res_tick,
  output logic [1:0]  res_status,
  output logic [2:0]  res_slot,
  output logic [7:0]  res_rem
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int QW = $clog2(RR_QUANTUM + 1);

  logic [7:0]  prio_r [NUM_SLOTS];
  logic [15:0] arr_r  [NUM_SLOTS];
  logic [7:0]  burst_r[NUM_SLOTS];
  logic [7:0]  rem_r  [NUM_SLOTS];

  logic [SW-1:0] cur_r;
  logic [15:0]   time_r;
  logic [QW-1:0] quant_r;

  logic [2:0]    pol_r;
  logic [SW-1:0] idx_r;      // scan counter
  logic          any_r;      // any unfinished slot
  logic          found_r;    // best candidate valid
  logic [SW-1:0] best_r;
  logic          keep_r;     // current slot keeps running
  logic          rrfound_r;  // rr: first ready slot after current

  // Slot under examination: for rr, walk in cyclic order after current
  logic [SW:0]   rr_sum;
  logic [SW-1:0] s;
  logic          rdy, cur_rdy, better;
  logic [7:0]    ks, kb;

  assign rr_sum = {1'b0, cur_r} + {1'b0, idx_r} + 1'b1;
  always_comb begin
    s = idx_r;
    if (pol_r == POL_RR) begin
      if (rr_sum >= (SW+1)'(NUM_SLOTS)) s = SW'(rr_sum - (SW+1)'(NUM_SLOTS));
      else s = rr_sum[SW-1:0];
    end
  end

  assign rdy = (rem_r[s] != 8'd0) && (arr_r[s] <= time_r);
  assign cur_rdy = (rem_r[cur_r] != 8'd0) && (arr_r[cur_r] <= time_r);

  always_comb begin
    case (pol_r)
      POL_SJF: begin ks = burst_r[s]; kb = burst_r[best_r]; end
      POL_PRIO: begin ks = prio_r[s]; kb = prio_r[best_r]; end
      POL_SRT: begin ks = rem_r[s]; kb = rem_r[best_r]; end
      default: begin ks = 8'd0; kb = 8'd0; end
    endcase
  end
  assign better = (ks < kb) || ((ks == kb) && (arr_r[s] < arr_r[best_r]));

  assign sts.scan_last = (idx_r == SW'(NUM_SLOTS - 1));

  // Scan state
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      pol_r <= (policy > POL_RR) ? POL_FCFS : policy;
      idx_r <= '0;
      any_r <= 1'b0;
      found_r <= 1'b0;
      rrfound_r <= 1'b0;
      best_r <= '0;
      keep_r <= 1'b0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + 1'b1;
      if (rem_r[s] != 8'd0) any_r <= 1'b1;
      if (idx_r == '0) begin
        if (pol_r == POL_RR)
          keep_r <= cur_rdy && (quant_r < QW'(RR_QUANTUM));
        else if (pol_r == POL_FCFS || pol_r == POL_SJF)
          keep_r <= cur_rdy && (rem_r[cur_r] < burst_r[cur_r]);
        else
          keep_r <= 1'b0;
      end
      if (pol_r == POL_RR) begin
        if (rdy && !rrfound_r) begin
          rrfound_r <= 1'b1;
          best_r <= s;
        end
      end else if (rdy && (!found_r || better)) begin
        found_r <= 1'b1;
        best_r <= s;
      end
    end
  end

  // Decision, table, and result register
  logic          pick_ok;
  logic [SW-1:0] pick;
  assign pick_ok = keep_r || ((pol_r == POL_RR) ? rrfound_r : found_r);
  assign pick = keep_r ? cur_r : best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) rem_r[i] <= 8'd0;
      cur_r <= '0;
      time_r <= 16'd0;
      quant_r <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !cmd.commit && !cmd.scan_start && !cmd.scan_step && !cmd.load)
        res_valid <= res_valid;
      if (cmd.load && (32'(in_slot) < NUM_SLOTS)) begin
        prio_r[SW'(in_slot)] <= in_prio;
        burst_r[SW'(in_slot)] <= in_burst;
        arr_r[SW'(in_slot)] <= in_arr;
        rem_r[SW'(in_slot)] <= in_burst;
      end
      if (cmd.commit) begin
        res_valid <= 1'b1;
        res_tick <= time_r;
        time_r <= time_r + 16'd1;
        res_slot <= 3'd0;
        res_rem <= 8'd0;
        if (!any_r) res_status <= ST_DONE;
        else if (!pick_ok) res_status <= ST_IDLE;
        else begin
          res_status <= ST_RUN;
          res_slot <= 3'(pick);
          res_rem <= rem_r[pick] - 8'd1;
          rem_r[pick] <= rem_r[pick] - 8'd1;
          cur_r <= pick;
          if (pol_r == POL_RR) quant_r <= keep_r ? quant_r + 1'b1 : QW'(1);
        end
      end else if (cmd.load) begin
        res_valid <= res_valid;
      end
    end
  end

endmodule

/* rtl/tps_checker.sv */
// Port-level checker for the tick process scheduler, bound to the top level.
// Depends on tick_process_scheduler_macros.svh and tps_pkg.
`include "tick_process_scheduler_macros.svh"
module tps_checker
  import tps_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  // A tick transaction makes the block busy next cycle
  `TPS_ASSERT_NEXT(a_tick_busy, in_tvalid && in_tready && in_tuser, !in_tready)
  // Status code never takes the unused value
  `TPS_ASSERT_IMPL(a_status_ok, out_tvalid, out_tdata[17:16] != 2'd3)
  // Idle or done results carry zero slot and remaining time
  `TPS_ASSERT_IMPL(a_zero_fields, out_tvalid && out_tdata[17:16] != ST_RUN,
                   out_tdata[28:18] == 11'd0)
  // A stalled result holds its data
  `TPS_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, $stable(out_tdata) && out_tvalid)
endmodule

bind tick_process_scheduler tps_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);

/* verif/tb_tick_process_scheduler.sv */
// Testbench for tick_process_scheduler: drives load and tick transactions,
// predicts each tick decision in a scoreboard class. Depends on tps_pkg.
`timescale 1ns / 1ps

module tb_tick_process_scheduler;
  import tps_pkg::*;

  localparam int NSLOT = 8;
  localparam int QUANTUM = 2;
  localparam int IDLE_LIMIT = 20000;

  // Scheduler predictor and queue of expected decisions
  class sched_scoreboard;
    logic [7:0]  prio_q [NSLOT];
    logic [15:0] arr_q [NSLOT];
    logic [7:0]  burst_q [NSLOT];
    logic [7:0]  rem_q [NSLOT];
    int unsigned cur_slot;
    logic [15:0] now_tick;
    int unsigned q_used;
    logic [2:0]  policy;
    logic [31:0] decisions [$];
    int          mismatches;

    function new();
      foreach (rem_q[i]) begin
        prio_q[i] = 0; arr_q[i] = 0; burst_q[i] = 0; rem_q[i] = 0;
      end
      cur_slot = 0; now_tick = 0; q_used = 0; policy = POL_FCFS; mismatches = 0;
    endfunction

    function bit ready(int unsigned s);
      return rem_q[s] != 0 && arr_q[s] <= now_tick;
    endfunction

    function int unsigned sort_key(int unsigned s, logic [2:0] pol);
      case (pol)
        POL_SJF:  return burst_q[s];
        POL_PRIO: return prio_q[s];
        POL_SRT:  return rem_q[s];
        default:  return 0;
      endcase
    endfunction

    // Note an accepted input; a tick pushes its expected result
    function void note_input(logic op, logic [2:0] idx, logic [7:0] pr, logic [7:0] bu,
                             logic [15:0] ar);
      int unsigned pick, best, ks, kb;
      logic [1:0] status;
      logic [7:0] rem;
      logic [2:0] pol;
      if (op == OP_LOAD) begin
        prio_q[idx] = pr; burst_q[idx] = bu; arr_q[idx] = ar; rem_q[idx] = bu;
        return;
      end
      pol = (policy > POL_RR) ? POL_FCFS : policy;
      pick = NSLOT; status = ST_DONE; rem = 0;
      foreach (rem_q[s]) if (rem_q[s] != 0) status = ST_IDLE;
      if (status == ST_IDLE) begin
        if (pol == POL_RR) begin
          if (ready(cur_slot) && q_used < QUANTUM) begin
            q_used++; pick = cur_slot;
          end else begin
            for (int i = 1; i <= NSLOT; i++) begin
              if (pick == NSLOT && ready((cur_slot + i) % NSLOT)) begin
                pick = (cur_slot + i) % NSLOT;
              end
            end
            if (pick < NSLOT) begin
              cur_slot = pick; q_used = 1;
            end
          end
        end else begin
          if (pol <= POL_SJF && ready(cur_slot) && rem_q[cur_slot] < burst_q[cur_slot]) begin
            pick = cur_slot;
          end else begin
            best = NSLOT;
            for (int s = 0; s < NSLOT; s++) begin
              if (ready(s)) begin
                if (best == NSLOT) best = s;
                else begin
                  ks = sort_key(s, pol); kb = sort_key(best, pol);
                  if (ks < kb || (ks == kb && arr_q[s] < arr_q[best])) best = s;
                end
              end
            end
            pick = best;
          end
          if (pick < NSLOT) cur_slot = pick;
        end
        if (pick < NSLOT) begin
          rem_q[pick] = rem_q[pick] - 8'd1;
          rem = rem_q[pick];
          status = ST_RUN;
        end
      end
      decisions.push_back({3'b000, (status == ST_RUN) ? rem : 8'd0,
                           (status == ST_RUN) ? pick[2:0] : 3'd0, status, now_tick});
      now_tick = now_tick + 16'd1;
    endfunction

    // Compare one result with the oldest expected decision
    function void check_result(logic [31:0] got);
      logic [31:0] want;
      bit bad;
      if (decisions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = decisions.pop_front();
      bad = (got[15:0] !== want[15:0]) || (got[17:16] !== want[17:16]) ||
            (got[20:18] !== want[20:18]) || (got[28:21] !== want[28:21]);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch tick/status/slot/rem exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                   want[15:0], want[17:16], want[20:18], want[28:21],
                   got[15:0], got[17:16], got[20:18], got[28:21]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_wdata = '0;

  sched_scoreboard sb;
  bit          no_gaps = 1'b0;
  bit          hold_out = 1'b0;
  bit          stim_done = 1'b0;
  int          quiet_cycles = 0;

  tick_process_scheduler u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Send one transaction, with a random idle gap before it; valid stays up
  // after acceptance until the next transaction or an explicit idle
  task automatic send_item(logic op, logic [2:0] idx, logic [7:0] pr, logic [7:0] bu,
                           logic [15:0] ar);
    while (!no_gaps && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, ar, bu, pr, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, idx, pr, bu, ar);
  endtask

  task automatic load_slot(logic [2:0] idx, logic [7:0] pr, logic [7:0] bu, logic [15:0] ar);
    send_item(OP_LOAD, idx, pr, bu, ar);
  endtask

  task automatic tick_once();
    send_item(OP_TICK, 3'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // Drain, then write the policy register while the block is idle
  task automatic set_policy(logic [2:0] pol);
    in_tvalid <= 1'b0;
    while (sb.decisions.size() != 0) @(posedge clk);
    repeat (NSLOT + 6) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= pol;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.policy = pol;
  endtask

  // Well-formed workload: one to six slots arriving near now, then ticks with occasional random loads
  task automatic run_batch(int n_ticks);
    int nload;
    nload = $urandom_range(1, 6);
    for (int i = 0; i < nload; i++)
      load_slot(3'($urandom), 8'($urandom_range(0, 7)), 8'($urandom_range(0, 6)),
                sb.now_tick + 16'($urandom_range(0, 8)));
    for (int i = 0; i < n_ticks; i++) begin
      if ($urandom_range(99) < 5)
        load_slot(3'($urandom), 8'($urandom), 8'($urandom_range(0, 9)),
                  16'($urandom));
      tick_once();
    end
  endtask

  // Receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (hold_out) out_tready <= 1'b0;
    else out_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 23);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n || hold_out ||
        stim_done)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all-done with nothing loaded, zero burst, extremes
    tick_once();
    load_slot(3'd0, 8'd0, 8'd0, 16'd0);
    tick_once();
    load_slot(3'd7, 8'd255, 8'd2, 16'hFFFF);
    tick_once();
    tick_once();
    load_slot(3'd1, 8'd255, 8'd255, 16'd0);
    load_slot(3'd2, 8'd0, 8'd1, 16'd1);
    load_slot(3'd3, 8'd5, 8'd3, 16'd0);
    repeat (4) tick_once();
    load_slot(3'd1, 8'd9, 8'd2, 16'd0);
    repeat (5) tick_once();

    // Every policy including out-of-range codes and the extremes
    for (int p = 0; p < 8; p++) begin
      set_policy(3'(p));
      run_batch(30);
    end

    // Random phases
    no_gaps = 1'b1;
    run_batch(60);
    no_gaps = 1'b0;
    for (int ph = 0; ph < 40; ph++) begin
      if (ph % 4 == 0) set_policy((ph % 12 == 0) ? 3'($urandom) : 3'($urandom_range(0, 4)));
      run_batch($urandom_range(10, 50));
    end

    // Long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_out = 1'b1;
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end
      run_batch(20);
    join

    // Round robin over two long slots
    set_policy(POL_RR);
    load_slot(3'd4, 8'd1, 8'd255, 16'd0);
    load_slot(3'd5, 8'd1, 8'd255, 16'd0);
    repeat (20) tick_once();

    in_tvalid <= 1'b0;
    stim_done = 1'b1;
    begin : drain
      int waited;
      waited = 0;
      while (sb.decisions.size() != 0 && waited < 100000) begin
        @(posedge clk);
        waited++;
      end
      repeat (NSLOT + 10) @(posedge clk);
      if (sb.decisions.size() == 0 && sb.mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
